// ===== rtl/core/rpi_pkg.sv =====
// Shared types, constants and helper functions of the road path integrator.
package rpi_pkg;

  localparam int ANGLE_BITS  = 16;
  localparam int COORD_BITS  = 40;
  localparam int TRIG_W      = 18;  // Q16 trig value, range [-1, 1]
  localparam int DELTA_W     = 24;  // step deltas and border offsets
  localparam int SUM_W       = ((COORD_BITS > DELTA_W) ? COORD_BITS : DELTA_W) + 1;
  localparam int PROD_W      = 2 * TRIG_W;
  localparam int CORDIC_ITER = 24;
  localparam int CDC_W       = 34;  // CORDIC x/y/z datapath width
  localparam int ITER_W      = 5;
  localparam logic signed [CDC_W-1:0] CORDIC_GAIN = CDC_W'(652032874);
  localparam logic [15:0] STEP_RESET = 16'd1024;

  typedef struct packed {
    logic               start_req;
    logic signed [15:0] roll_angle;
    logic signed [15:0] slope_angle;
    logic signed [15:0] heading_angle;
    logic        [15:0] road_width;
  } rpi_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic signed [COORD_BITS-1:0] center_z;
    logic signed [COORD_BITS-1:0] left_x;
    logic signed [COORD_BITS-1:0] left_y;
    logic signed [COORD_BITS-1:0] left_z;
    logic signed [COORD_BITS-1:0] right_x;
    logic signed [COORD_BITS-1:0] right_y;
    logic signed [COORD_BITS-1:0] right_z;
  } rpi_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TGO,
    S_TWAIT,
    S_MUL,
    S_MPOST,
    S_ADD,
    S_OUT
  } rpi_state_e;

  // arctan(2^-i) in units of pi/2^31
  function automatic logic signed [CDC_W-1:0] atan_lut(input logic [ITER_W-1:0] idx);
    logic [31:0] v;
    begin
      case (idx)
        5'd0:  v = 32'h20000000;
        5'd1:  v = 32'h12E4051D;
        5'd2:  v = 32'h09FB385B;
        5'd3:  v = 32'h051111D4;
        5'd4:  v = 32'h028B0D43;
        5'd5:  v = 32'h0145D7E1;
        5'd6:  v = 32'h00A2F61E;
        5'd7:  v = 32'h00517C55;
        5'd8:  v = 32'h0028BE53;
        5'd9:  v = 32'h00145F2E;
        5'd10: v = 32'h000A2F98;
        5'd11: v = 32'h000517CC;
        5'd12: v = 32'h00028BE6;
        5'd13: v = 32'h000145F3;
        5'd14: v = 32'h0000A2F9;
        5'd15: v = 32'h0000517C;
        5'd16: v = 32'h000028BE;
        5'd17: v = 32'h0000145F;
        5'd18: v = 32'h00000A2F;
        5'd19: v = 32'h00000517;
        5'd20: v = 32'h0000028B;
        5'd21: v = 32'h00000145;
        5'd22: v = 32'h000000A2;
        5'd23: v = 32'h00000051;
        default: v = 32'h0;
      endcase
      atan_lut = CDC_W'(v);
    end
  endfunction

  // clamp a wide sum to the signed coordinate range
  function automatic logic signed [COORD_BITS-1:0] sat_coord(
      input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    begin
      hi = (SUM_W'(1) <<< (COORD_BITS - 1)) - SUM_W'(1);
      lo = -hi - SUM_W'(1);
      if (s > hi) begin
        sat_coord = hi[COORD_BITS-1:0];
      end else if (s < lo) begin
        sat_coord = lo[COORD_BITS-1:0];
      end else begin
        sat_coord = s[COORD_BITS-1:0];
      end
    end
  endfunction

endpackage

// ===== rtl/core/rpi_cordic.sv =====
// Iterative rotation CORDIC: one micro-rotation per cycle, Q16 sine and cosine out.
module rpi_cordic
  import rpi_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [15:0]       angle_i,
  output logic                     done_o,
  output logic signed [TRIG_W-1:0] sin_o,
  output logic signed [TRIG_W-1:0] cos_o
);

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [ITER_W-1:0]       iter_q, iter_d;
  logic signed [CDC_W-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [1:0]              quad_q, quad_d;

  logic [31:0]             phase, phase_r, resid;
  logic [1:0]              quad_in;
  logic signed [CDC_W-1:0] dx, dy, xr, yr;
  logic signed [TRIG_W-1:0] c_cl, s_cl;

  // quadrant reduction of the binary angle
  always_comb begin
    phase   = 32'(signed'(angle_i)) << (32 - ANGLE_BITS);
    phase_r = phase + 32'h2000_0000;
    quad_in = phase_r[31:30];
    resid   = phase - {quad_in, 30'd0};
  end

  // load on start, else one micro-rotation while busy
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    iter_d = iter_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    quad_d = quad_q;
    dx     = y_q >>> iter_q;
    dy     = x_q >>> iter_q;
    if (start_i) begin
      busy_d = 1'b1;
      iter_d = '0;
      x_d    = CORDIC_GAIN;
      y_d    = '0;
      z_d    = CDC_W'(signed'(resid));
      quad_d = quad_in;
    end else if (busy_q) begin
      if (z_q >= 0) begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - atan_lut(iter_q);
      end else begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + atan_lut(iter_q);
      end
      iter_d = iter_q + ITER_W'(1);
      if (iter_q == ITER_W'(CORDIC_ITER - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    quad_q <= quad_d;
  end

  // round to Q16, clamp to unit range, map back to the quadrant
  always_comb begin
    xr = (x_q + CDC_W'(8192)) >>> 14;
    yr = (y_q + CDC_W'(8192)) >>> 14;
    if (xr > CDC_W'(65536)) begin
      c_cl = TRIG_W'(65536);
    end else if (xr < -CDC_W'(65536)) begin
      c_cl = -TRIG_W'(65536);
    end else begin
      c_cl = xr[TRIG_W-1:0];
    end
    if (yr > CDC_W'(65536)) begin
      s_cl = TRIG_W'(65536);
    end else if (yr < -CDC_W'(65536)) begin
      s_cl = -TRIG_W'(65536);
    end else begin
      s_cl = yr[TRIG_W-1:0];
    end
    case (quad_q)
      2'd0: begin cos_o = c_cl;  sin_o = s_cl;  end
      2'd1: begin cos_o = -s_cl; sin_o = c_cl;  end
      2'd2: begin cos_o = -c_cl; sin_o = -s_cl; end
      default: begin cos_o = s_cl; sin_o = -c_cl; end
    endcase
  end

  assign done_o = done_q;

endmodule

// ===== rtl/core/road_path_integrator_core.sv =====
// Road path integrator: 3D dead reckoning of a road center line with borders.
// One word in gives one word out. A segment word runs three sine-cosine
// evaluations on one iterative CORDIC (each a start, then 24 micro-rotations
// and the done strobe), ten products on one shared 18x18 multiplier (a
// multiply step and a rounding step each) and nine saturating adds on one
// adder. A start word skips the trig and products and goes straight to the
// adds.
// The input is not ready while a word is in work or its result waits to be taken.
// The step length register may be written at any cycle while the block is idle.
module road_path_integrator_core
  import rpi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  rpi_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rpi_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  rpi_state_e state_q, state_d;

  logic [15:0] step_q;
  rpi_in_t     in_q;
  logic [1:0]  tcnt_q;
  logic [3:0]  mcnt_q;
  logic [3:0]  acnt_q;

  logic signed [TRIG_W-1:0]     sa_q, ca_q, sb_q, cb_q, st_q, ct_q;
  logic signed [TRIG_W-1:0]     pa_q, pb_q, pc_q, pd_q;
  logic signed [DELTA_W-1:0]    dx_q, dy_q, dz_q, ox_q, oy_q, oz_q;
  logic signed [COORD_BITS-1:0] px_q, py_q, pz_q;
  logic signed [COORD_BITS-1:0] lx_q, ly_q, lz_q, rx_q, ry_q, rz_q;
  logic signed [PROD_W-1:0]     prod_q;

  logic                     cdc_start, cdc_done;
  logic signed [15:0]       cdc_angle;
  logic signed [TRIG_W-1:0] cdc_sin, cdc_cos;

  logic signed [TRIG_W-1:0]  mul_a, mul_b, len_s, wid_s;
  logic signed [PROD_W-1:0]  rnd16, rnd10, rnd11;
  logic signed [SUM_W-1:0]   add_a, add_b;
  logic signed [COORD_BITS-1:0] add_res;
  logic signed [DELTA_W-1:0] add_sel;

  assign cfg_ready_o = 1'b1;

  rpi_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cdc_start),
    .angle_i (cdc_angle),
    .done_o  (cdc_done),
    .sin_o   (cdc_sin),
    .cos_o   (cdc_cos)
  );

  // angle order: roll, slope, heading
  always_comb begin
    case (tcnt_q)
      2'd0:    cdc_angle = in_q.roll_angle;
      2'd1:    cdc_angle = in_q.slope_angle;
      default: cdc_angle = in_q.heading_angle;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = in_data_i.start_req ? S_ADD : S_TGO;
      S_TGO:   state_d = S_TWAIT;
      S_TWAIT: if (cdc_done) state_d = (tcnt_q == 2'd2) ? S_MUL : S_TGO;
      S_MUL:   state_d = S_MPOST;
      S_MPOST: if (mcnt_q == 4'd9) state_d = S_ADD; else state_d = S_MUL;
      S_ADD:   if (acnt_q == 4'd8) state_d = S_OUT;
      S_OUT:   if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // handshake and unit control
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cdc_start   = 1'b0;
    unique case (state_q)
      S_IDLE:  in_ready_o  = 1'b1;
      S_TGO:   cdc_start   = 1'b1;
      S_OUT:   out_valid_o = 1'b1;
      default: ;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    len_s = TRIG_W'({2'b00, step_q});
    wid_s = TRIG_W'({2'b00, in_q.road_width});
    case (mcnt_q)
      4'd0:    begin mul_a = st_q;  mul_b = cb_q; end
      4'd1:    begin mul_a = ct_q;  mul_b = cb_q; end
      4'd2:    begin mul_a = ct_q;  mul_b = ca_q; end
      4'd3:    begin mul_a = st_q;  mul_b = ca_q; end
      4'd4:    begin mul_a = len_s; mul_b = pa_q; end
      4'd5:    begin mul_a = len_s; mul_b = sb_q; end
      4'd6:    begin mul_a = len_s; mul_b = pb_q; end
      4'd7:    begin mul_a = wid_s; mul_b = pc_q; end
      4'd8:    begin mul_a = wid_s; mul_b = sa_q; end
      default: begin mul_a = wid_s; mul_b = pd_q; end
    endcase
    rnd16 = (prod_q + PROD_W'(32768)) >>> 16;
    rnd10 = (prod_q + PROD_W'(512)) >>> 10;
    rnd11 = (prod_q + PROD_W'(1024)) >>> 11;
  end

  // shared saturating adder operand select
  always_comb begin
    case (acnt_q)
      4'd0, 4'd3, 4'd6: add_a = SUM_W'(px_q);
      4'd1, 4'd4, 4'd7: add_a = SUM_W'(py_q);
      default:          add_a = SUM_W'(pz_q);
    endcase
    case (acnt_q)
      4'd0:           add_sel = dx_q;
      4'd1:           add_sel = dy_q;
      4'd2:           add_sel = dz_q;
      4'd3, 4'd6:     add_sel = ox_q;
      4'd4, 4'd7:     add_sel = oy_q;
      default:        add_sel = oz_q;
    endcase
    add_b = (acnt_q >= 4'd6) ? -SUM_W'(add_sel) : SUM_W'(add_sel);
    add_res = sat_coord(add_a + add_b);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= STEP_RESET;
      tcnt_q  <= '0;
      mcnt_q  <= '0;
      acnt_q  <= '0;
      px_q    <= '0;
      py_q    <= '0;
      pz_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) step_q <= cfg_data_i;
      if (state_q == S_IDLE) begin
        tcnt_q <= '0;
        mcnt_q <= '0;
        acnt_q <= '0;
        if (in_valid_i && in_data_i.start_req) begin
          px_q <= '0;
          py_q <= '0;
          pz_q <= '0;
        end
      end
      if (state_q == S_TWAIT && cdc_done) tcnt_q <= tcnt_q + 2'd1;
      if (state_q == S_MPOST) mcnt_q <= mcnt_q + 4'd1;
      if (state_q == S_ADD) begin
        acnt_q <= acnt_q + 4'd1;
        case (acnt_q)
          4'd0:    px_q <= add_res;
          4'd1:    py_q <= add_res;
          4'd2:    pz_q <= add_res;
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      in_q <= in_data_i;
      dx_q <= '0;
      dy_q <= '0;
      dz_q <= '0;
      ox_q <= DELTA_W'({in_data_i.road_width, 5'd0});
      oy_q <= '0;
      oz_q <= '0;
    end
    if (state_q == S_TWAIT && cdc_done) begin
      case (tcnt_q)
        2'd0:    begin sa_q <= cdc_sin; ca_q <= cdc_cos; end
        2'd1:    begin sb_q <= cdc_sin; cb_q <= cdc_cos; end
        default: begin st_q <= cdc_sin; ct_q <= cdc_cos; end
      endcase
    end
    if (state_q == S_MUL) prod_q <= mul_a * mul_b;
    if (state_q == S_MPOST) begin
      case (mcnt_q)
        4'd0:    pa_q <= rnd16[TRIG_W-1:0];
        4'd1:    pb_q <= rnd16[TRIG_W-1:0];
        4'd2:    pc_q <= rnd16[TRIG_W-1:0];
        4'd3:    pd_q <= rnd16[TRIG_W-1:0];
        4'd4:    dx_q <= rnd10[DELTA_W-1:0];
        4'd5:    dy_q <= rnd10[DELTA_W-1:0];
        4'd6:    dz_q <= rnd10[DELTA_W-1:0];
        4'd7:    ox_q <= rnd11[DELTA_W-1:0];
        4'd8:    oy_q <= -rnd11[DELTA_W-1:0];
        default: oz_q <= -rnd11[DELTA_W-1:0];
      endcase
    end
    if (state_q == S_ADD) begin
      case (acnt_q)
        4'd3:    lx_q <= add_res;
        4'd4:    ly_q <= add_res;
        4'd5:    lz_q <= add_res;
        4'd6:    rx_q <= add_res;
        4'd7:    ry_q <= add_res;
        4'd8:    rz_q <= add_res;
        default: ;
      endcase
    end
  end

  // result word
  always_comb begin
    out_data_o.center_x = px_q;
    out_data_o.center_y = py_q;
    out_data_o.center_z = pz_q;
    out_data_o.left_x   = lx_q;
    out_data_o.left_y   = ly_q;
    out_data_o.left_z   = lz_q;
    out_data_o.right_x  = rx_q;
    out_data_o.right_y  = ry_q;
    out_data_o.right_z  = rz_q;
  end

endmodule
